// ===== design/easing_curve_evaluator_defines.svh =====
// ----------------------------------------------------------------------------
// Easing curve evaluator assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef EASING_CURVE_EVALUATOR_DEFINES_SVH
`define EASING_CURVE_EVALUATOR_DEFINES_SVH

// same-cycle implication
`define ECE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ECE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ece_pkg.sv =====
// ----------------------------------------------------------------------------
// Easing curve evaluator package
// Fixed-point constants, curve codes, pipeline depths and shared types.
// ----------------------------------------------------------------------------
package ece_pkg;

  localparam int FRAC_BITS = 16;

  localparam logic [3:0] CURVE_LINEAR     = 4'd0;
  localparam logic [3:0] CURVE_SMOOTH     = 4'd1;
  localparam logic [3:0] CURVE_SMOOTH_SQ  = 4'd2;
  localparam logic [3:0] CURVE_SMOOTHER   = 4'd3;
  localparam logic [3:0] CURVE_RUSH_INTO  = 4'd4;
  localparam logic [3:0] CURVE_RUSH_FROM  = 4'd5;
  localparam logic [3:0] CURVE_BACK       = 4'd6;
  localparam logic [3:0] CURVE_ELASTIC    = 4'd7;
  localparam logic [3:0] CURVE_THERE_BACK = 4'd8;

  localparam logic REG_CURVE_SELECT = 1'b0;

  localparam logic [16:0] ONE      = 17'h10000;
  localparam logic [16:0] BACK_C1  = 17'd111515;
  localparam logic [17:0] BACK_C3  = 18'd177051;
  localparam logic [15:0] EXP_A    = 16'd43024;
  localparam logic [13:0] EXP_B    = 14'd10256;
  localparam logic [17:0] SIN_R    = 18'd196608;
  localparam logic [16:0] SIN_H    = 17'd98304;
  localparam logic [18:0] RECIP3   = 19'd349526;

  localparam int ECE_LAT_POLY    = 7;
  localparam int ECE_LAT_ELASTIC = 26;
  localparam int ECE_DIV_STAGES  = 17;
  localparam int ECE_LAT         = ECE_LAT_ELASTIC + 1;
  localparam int ECE_DLY         = ECE_LAT_ELASTIC - ECE_LAT_POLY;

  typedef struct packed {
    logic [16:0] ex;
    logic        neg;
  } div_side_t;

  typedef struct packed {
    logic signed [18:0] res;
    logic               use_el;
  } poly_out_t;

  function automatic logic signed [47:0] fx_rnd(input logic signed [47:0] p);
    fx_rnd = (p + (48'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

endpackage

// ===== design/ece_div.sv =====
// ----------------------------------------------------------------------------
// Easing curve evaluator divider
// Restoring divider, one quotient bit per register stage, with sideband.
// ----------------------------------------------------------------------------
module ece_div (
  input  logic                clk,
  input  logic                adv,
  input  logic [18:0]         rem0,
  input  logic [18:0]         den,
  input  ece_pkg::div_side_t  side,
  output logic [16:0]         quo,
  output ece_pkg::div_side_t  side_out
);
  import ece_pkg::*;

  logic [18:0] rem_q  [ECE_DIV_STAGES];
  logic [18:0] den_q  [ECE_DIV_STAGES];
  logic [16:0] quo_q  [ECE_DIV_STAGES];
  div_side_t   side_q [ECE_DIV_STAGES];

  for (genvar j = 0; j < ECE_DIV_STAGES; j++) begin : g_stage
    logic [18:0] rem_in;
    logic [18:0] den_in;
    logic [16:0] quo_in;
    div_side_t   side_in;
    logic [19:0] trial;
    logic        ge;

    if (j == 0) begin : g_first
      assign rem_in  = rem0;
      assign den_in  = den;
      assign quo_in  = '0;
      assign side_in = side;
    end else begin : g_rest
      assign rem_in  = rem_q[j-1];
      assign den_in  = den_q[j-1];
      assign quo_in  = quo_q[j-1];
      assign side_in = side_q[j-1];
    end

    assign trial = {rem_in, 1'b0};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_q[j]  <= ge ? 19'(trial - {1'b0, den_in}) : trial[18:0];
        den_q[j]  <= den_in;
        quo_q[j]  <= {quo_in[15:0], ge};
        side_q[j] <= side_in;
      end
    end
  end

  assign quo      = quo_q[ECE_DIV_STAGES-1];
  assign side_out = side_q[ECE_DIV_STAGES-1];

endmodule

// ===== design/ece_poly.sv =====
// ----------------------------------------------------------------------------
// Easing curve evaluator polynomial pipeline
// Smoothstep family, smootherstep, back and linear curves in seven stages.
// ----------------------------------------------------------------------------
module ece_poly (
  input  logic               clk,
  input  logic               adv,
  input  logic [16:0]        tc,
  input  logic [3:0]         sel,
  output ece_pkg::poly_out_t pout
);
  import ece_pkg::*;

  // stage 1
  logic signed [18:0] d;
  logic [17:0]        ad;
  logic [19:0]        t6;
  logic [16:0]        x_next;
  logic [16:0]        p1_x, p1_t;
  logic signed [17:0] p1_u;
  logic signed [20:0] p1_w;
  logic [3:0]         p1_sel;

  assign d  = $signed({1'b0, tc, 1'b0}) - 19'sd65536;
  assign ad = d[18] ? 18'(-d) : d[17:0];
  assign t6 = {1'b0, tc, 2'b0} + {2'b0, tc, 1'b0};

  always_comb begin
    case (sel)
      CURVE_RUSH_INTO:  x_next = 17'(({1'b0, tc} + {1'b0, ONE}) >> 1);
      CURVE_RUSH_FROM:  x_next = tc >> 1;
      CURVE_THERE_BACK: x_next = 17'({1'b0, ONE} - ad);
      default:          x_next = tc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_x   <= x_next;
      p1_t   <= tc;
      p1_u   <= $signed({1'b0, tc}) - 18'sd65536;
      p1_w   <= $signed({1'b0, t6}) - 21'sd983040;
      p1_sel <= sel;
    end
  end

  // stage 2
  logic [33:0]        p2_xx, p2_tt;
  logic signed [35:0] p2_uu;
  logic signed [38:0] p2_tw;
  logic [16:0]        p2_x, p2_t;
  logic signed [17:0] p2_u;
  logic [3:0]         p2_sel;

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_xx  <= p1_x * p1_x;
      p2_tt  <= p1_t * p1_t;
      p2_uu  <= p1_u * p1_u;
      p2_tw  <= $signed({1'b0, p1_t}) * p1_w;
      p2_x   <= p1_x;
      p2_t   <= p1_t;
      p2_u   <= p1_u;
      p2_sel <= p1_sel;
    end
  end

  // stage 3
  logic signed [47:0] xx_r, tt_r, uu_r, tw_r;
  logic [16:0]        p3_x2, p3_t2, p3_u2, p3_x, p3_t;
  logic signed [20:0] p3_in;
  logic signed [17:0] p3_u;
  logic [3:0]         p3_sel;

  assign xx_r = fx_rnd($signed({14'b0, p2_xx}));
  assign tt_r = fx_rnd($signed({14'b0, p2_tt}));
  assign uu_r = fx_rnd({{12{p2_uu[35]}}, p2_uu});
  assign tw_r = fx_rnd({{9{p2_tw[38]}}, p2_tw});

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_x2  <= xx_r[16:0];
      p3_t2  <= tt_r[16:0];
      p3_u2  <= uu_r[16:0];
      p3_in  <= tw_r[20:0] + 21'sd655360;
      p3_x   <= p2_x;
      p3_t   <= p2_t;
      p3_u   <= p2_u;
      p3_sel <= p2_sel;
    end
  end

  // stage 4
  logic [17:0]        tx;
  logic [34:0]        p4_sx;
  logic signed [36:0] p4_u3p;
  logic [33:0]        p4_t3p, p4_cu;
  logic signed [20:0] p4_in;
  logic [16:0]        p4_t;
  logic [3:0]         p4_sel;

  assign tx = 18'd196608 - {p3_x, 1'b0};

  always_ff @(posedge clk) begin
    if (adv) begin
      p4_sx  <= p3_x2 * tx;
      p4_u3p <= $signed({1'b0, p3_u2}) * p3_u;
      p4_t3p <= p3_t2 * p3_t;
      p4_cu  <= BACK_C1 * p3_u2;
      p4_in  <= p3_in;
      p4_t   <= p3_t;
      p4_sel <= p3_sel;
    end
  end

  // stage 5
  logic signed [47:0] sx_r, u3_r, t3_r, cu_r;
  logic [16:0]        p5_s, p5_t3, p5_c, p5_t;
  logic signed [17:0] p5_u3;
  logic signed [20:0] p5_in;
  logic [3:0]         p5_sel;

  assign sx_r = fx_rnd($signed({13'b0, p4_sx}));
  assign u3_r = fx_rnd({{11{p4_u3p[36]}}, p4_u3p});
  assign t3_r = fx_rnd($signed({14'b0, p4_t3p}));
  assign cu_r = fx_rnd($signed({14'b0, p4_cu}));

  always_ff @(posedge clk) begin
    if (adv) begin
      p5_s   <= sx_r[16:0];
      p5_u3  <= u3_r[17:0];
      p5_t3  <= t3_r[16:0];
      p5_c   <= cu_r[16:0];
      p5_in  <= p4_in;
      p5_t   <= p4_t;
      p5_sel <= p4_sel;
    end
  end

  // stage 6
  logic [33:0]        p6_ss;
  logic signed [36:0] p6_bk;
  logic signed [38:0] p6_sm;
  logic [16:0]        p6_s, p6_c, p6_t;
  logic [3:0]         p6_sel;

  always_ff @(posedge clk) begin
    if (adv) begin
      p6_ss  <= p5_s * p5_s;
      p6_bk  <= $signed({1'b0, BACK_C3}) * p5_u3;
      p6_sm  <= $signed({1'b0, p5_t3}) * p5_in;
      p6_s   <= p5_s;
      p6_c   <= p5_c;
      p6_t   <= p5_t;
      p6_sel <= p5_sel;
    end
  end

  // stage 7
  logic signed [47:0] ss_r, bk_r, sm_r;
  logic signed [21:0] s22, t22, c22, one22, r;
  logic signed [18:0] r_sat;

  assign ss_r  = fx_rnd($signed({14'b0, p6_ss}));
  assign bk_r  = fx_rnd({{11{p6_bk[36]}}, p6_bk});
  assign sm_r  = fx_rnd({{9{p6_sm[38]}}, p6_sm});
  assign s22   = $signed({5'b0, p6_s});
  assign t22   = $signed({5'b0, p6_t});
  assign c22   = $signed({5'b0, p6_c});
  assign one22 = $signed({5'b0, ONE});

  always_comb begin
    case (p6_sel)
      CURVE_SMOOTH, CURVE_THERE_BACK: r = s22;
      CURVE_SMOOTH_SQ:  r = ss_r[21:0];
      CURVE_SMOOTHER:   r = sm_r[21:0];
      CURVE_RUSH_INTO:  r = (s22 <<< 1) - one22;
      CURVE_RUSH_FROM:  r = s22 <<< 1;
      CURVE_BACK:       r = one22 + bk_r[21:0] + c22;
      CURVE_ELASTIC:    r = (p6_t == '0) ? '0 : one22;
      default:          r = t22;
    endcase
    if (r > 22'sd262143) begin
      r_sat = 19'sd262143;
    end else if (r < -22'sd262144) begin
      r_sat = -19'sd262144;
    end else begin
      r_sat = r[18:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pout.res    <= r_sat;
      pout.use_el <= (p6_sel == CURVE_ELASTIC) && (p6_t != '0) && (p6_t != ONE);
    end
  end

endmodule

// ===== design/ece_elastic.sv =====
// ----------------------------------------------------------------------------
// Easing curve evaluator elastic path
// Fixed-point exp2 and Bhaskara sine with a pipelined divide, 26 stages.
// ----------------------------------------------------------------------------
module ece_elastic (
  input  logic               clk,
  input  logic               adv,
  input  logic [16:0]        tc,
  output logic signed [19:0] el
);
  import ece_pkg::*;

  // stage 1
  logic [19:0]        e;
  logic [3:0]         e1_n;
  logic [15:0]        e1_f;
  logic signed [20:0] e1_a;

  assign e = {tc, 3'b0} + {2'b0, tc, 1'b0};

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_n <= e[19:16];
      e1_f <= e[15:0];
      e1_a <= $signed({1'b0, e}) - 21'sd49152;
    end
  end

  // stage 2: fold phase into one period
  logic signed [20:0] r1, r2, r3, m_full;
  logic [31:0]        e2_paf, e2_pff;
  logic [3:0]         e2_n;
  logic [17:0]        e2_m;

  assign r1 = $signed({3'b0, SIN_R});
  assign r2 = r1 <<< 1;
  assign r3 = r1 + r2;

  always_comb begin
    if (e1_a < 0) begin
      m_full = e1_a + r1;
    end else if (e1_a >= r3) begin
      m_full = e1_a - r3;
    end else if (e1_a >= r2) begin
      m_full = e1_a - r2;
    end else if (e1_a >= r1) begin
      m_full = e1_a - r1;
    end else begin
      m_full = e1_a;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e2_paf <= EXP_A * e1_f;
      e2_pff <= e1_f * e1_f;
      e2_n   <= e1_n;
      e2_m   <= m_full[17:0];
    end
  end

  // stage 3
  logic signed [47:0] paf_r, pff_r;
  logic               neg_next;
  logic [16:0]        h;
  logic [16:0]        e3_pa, e3_ff;
  logic [3:0]         e3_n;
  logic               e3_neg;
  logic [36:0]        e3_prh;

  assign paf_r    = fx_rnd($signed({16'b0, e2_paf}));
  assign pff_r    = fx_rnd($signed({16'b0, e2_pff}));
  assign neg_next = e2_m >= {1'b0, SIN_H};
  assign h        = neg_next ? 17'(e2_m - {1'b0, SIN_H}) : e2_m[16:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      e3_pa  <= paf_r[16:0];
      e3_ff  <= pff_r[16:0];
      e3_n   <= e2_n;
      e3_neg <= neg_next;
      e3_prh <= {h, 1'b0} * RECIP3;
    end
  end

  // stage 4
  logic [30:0] e4_pbf;
  logic [16:0] e4_pa;
  logic [3:0]  e4_n;
  logic        e4_neg;
  logic [15:0] e4_hn;

  always_ff @(posedge clk) begin
    if (adv) begin
      e4_pbf <= EXP_B * e3_ff;
      e4_pa  <= e3_pa;
      e4_n   <= e3_n;
      e4_neg <= e3_neg;
      e4_hn  <= e3_prh[35:20];
    end
  end

  // stage 5
  logic signed [47:0] pbf_r;
  logic signed [18:0] p_s;
  logic [16:0]        e5_p;
  logic [32:0]        e5_pg;
  logic [3:0]         e5_n;
  logic               e5_neg;

  assign pbf_r = fx_rnd($signed({17'b0, e4_pbf}));
  assign p_s   = 19'sd65536 - $signed({2'b0, e4_pa}) + pbf_r[18:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      e5_p   <= p_s[16:0];
      e5_pg  <= e4_hn * 17'(ONE - {1'b0, e4_hn});
      e5_n   <= e4_n;
      e5_neg <= e4_neg;
    end
  end

  // stage 6
  logic signed [47:0] pg_r;
  logic [16:0]        e6_ex;
  logic [14:0]        e6_g;
  logic               e6_neg;

  assign pg_r = fx_rnd($signed({15'b0, e5_pg}));

  always_ff @(posedge clk) begin
    if (adv) begin
      e6_ex  <= e5_p >> e5_n;
      e6_g   <= pg_r[14:0];
      e6_neg <= e5_neg;
    end
  end

  // stages 7 to 23: 16 g ONE / (5 ONE - 4 g)
  div_side_t   side_in, side_out;
  logic [16:0] quo;

  assign side_in.ex  = e6_ex;
  assign side_in.neg = e6_neg;

  ece_div u_div (
    .clk      (clk),
    .adv      (adv),
    .rem0     ({1'b0, e6_g, 3'b0}),
    .den      (19'd327680 - {2'b0, e6_g, 2'b0}),
    .side     (side_in),
    .quo      (quo),
    .side_out (side_out)
  );

  // stages 24 to 26
  logic signed [17:0] e24_s;
  logic [16:0]        e24_ex;
  logic signed [35:0] e25_pr;
  logic signed [47:0] pr_r;

  assign pr_r = fx_rnd({{12{e25_pr[35]}}, e25_pr});

  always_ff @(posedge clk) begin
    if (adv) begin
      e24_s  <= side_out.neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
      e24_ex <= side_out.ex;
      e25_pr <= $signed({1'b0, e24_ex}) * e24_s;
      el     <= $signed({3'b0, ONE}) + pr_r[19:0];
    end
  end

endmodule

// ===== design/easing_curve_evaluator.sv =====
// ----------------------------------------------------------------------------
// Easing curve evaluator
// Eases a Q3.16 progress word along the curve chosen in curve_select.
// ----------------------------------------------------------------------------
// Takes one progress word per cycle and returns one eased word per progress
// word, in order, after the input register, the 26 stages of the elastic path
// with its one-bit-per-stage divider and the output register.
// Every curve runs through the same depth. The whole pipeline holds while
// eased_stall is high and a result waits; progress_stall follows that hold.
// Write curve_select at byte address 0 only while no word is in flight.
`include "easing_curve_evaluator_defines.svh"

module easing_curve_evaluator (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               progress_valid,
  output logic               progress_stall,
  input  logic signed [18:0] progress,
  output logic               eased_valid,
  input  logic               eased_stall,
  output logic signed [18:0] eased_value
);
  import ece_pkg::*;

  logic [3:0]         curve_select;
  logic               cfg_wr;
  logic               adv;
  logic [ECE_LAT:0]   vld;
  logic [16:0]        r0_t;
  logic [3:0]         r0_sel;
  logic [16:0]        tc_next;
  poly_out_t          poly_o;
  poly_out_t          pd [ECE_DLY];
  logic signed [19:0] el;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_CURVE_SELECT) ? {28'b0, curve_select} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_select <= CURVE_LINEAR;
    end else if (cfg_wr && paddr[2] == REG_CURVE_SELECT) begin
      curve_select <= pwdata[3:0];
    end
  end

  assign adv            = !(eased_valid && eased_stall);
  assign progress_stall = !adv;
  assign eased_valid    = vld[ECE_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[ECE_LAT-1:0], progress_valid};
    end
  end

  always_comb begin
    if (progress[18]) begin
      tc_next = '0;
    end else if (progress[17:0] > {1'b0, ONE}) begin
      tc_next = ONE;
    end else begin
      tc_next = progress[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r0_t   <= tc_next;
      r0_sel <= curve_select;
    end
  end

  ece_poly u_poly (
    .clk  (clk),
    .adv  (adv),
    .tc   (r0_t),
    .sel  (r0_sel),
    .pout (poly_o)
  );

  ece_elastic u_elastic (
    .clk (clk),
    .adv (adv),
    .tc  (r0_t),
    .el  (el)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      pd[0] <= poly_o;
      for (int i = 1; i < ECE_DLY; i++) begin
        pd[i] <= pd[i-1];
      end
      eased_value <= pd[ECE_DLY-1].use_el ? el[18:0] : pd[ECE_DLY-1].res;
    end
  end

  `ECE_ASSERT_NEXT(a_advance, vld[ECE_LAT-1] && !progress_stall, eased_valid, "word lost at output")
  `ECE_ASSERT_NOW(a_reset_empty, $past(rst), !eased_valid, "output valid after reset")
  `ECE_ASSERT_NEXT(a_cfg_hold, !cfg_wr, $stable(curve_select), "curve_select changed without write")

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Easing curve evaluator testbench
// Drives random and edge progress words through every curve, predicts each
// eased word in fixed point and compares it in order against the block.
// ----------------------------------------------------------------------------

class eased_scoreboard;
  logic signed [18:0] pending_q[$];
  int errors;

  function void note_progress(logic signed [18:0] v);
    pending_q.push_back(v);
  endfunction

  function void check_eased(logic signed [18:0] act);
    logic signed [18:0] exp_v;
    if (pending_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected eased word %0d", act);
      return;
    end
    exp_v = pending_q.pop_front();
    if (exp_v !== act) begin
      errors++;
      if (errors <= 10) $display("eased mismatch: expected %0d actual %0d", exp_v, act);
    end
  endfunction
endclass

module tb;
  import ece_pkg::*;

  localparam longint UNIT = 64'sd1 << FRAC_BITS;

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic progress_valid = 0, progress_stall;
  logic signed [18:0] progress = '0;
  logic eased_valid, eased_stall = 0;
  logic signed [18:0] eased_value;

  eased_scoreboard sb;
  logic [3:0] cur_curve = CURVE_LINEAR;
  int send_idle = 0, recv_idle = 0;
  bit hold_off = 0;

  easing_curve_evaluator u_top (.*);

  initial forever #1 clk = ~clk;

  function automatic longint floor_sh(longint p);
    return p >>> FRAC_BITS;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return floor_sh(a * b + (UNIT >> 1));
  endfunction

  function automatic longint clamp_t(longint x);
    if (x < 0) return 0;
    if (x > UNIT) return UNIT;
    return x;
  endfunction

  function automatic longint smooth_of(longint x);
    x = clamp_t(x);
    return qmul(qmul(x, x), 3 * UNIT - 2 * x);
  endfunction

  function automatic longint pow2_neg(longint e);
    longint n, f, ca, cb, p;
    n = e >>> FRAC_BITS;
    f = e & (UNIT - 1);
    ca = (6565 * UNIT + 5000) / 10000;
    cb = (1565 * UNIT + 5000) / 10000;
    p = UNIT - qmul(ca, f) + qmul(cb, qmul(f, f));
    if (n > 62) return 0;
    return p >>> n;
  endfunction

  function automatic longint wave_of(longint a);
    longint r, half, m, h, hn, g, s;
    bit neg;
    r = 3 * UNIT;
    half = r / 2;
    m = a % r;
    neg = 0;
    if (m < 0) m += r;
    if (m < half) h = m;
    else begin
      h = m - half;
      neg = 1;
    end
    hn = (h * UNIT) / half;
    g = qmul(hn, UNIT - hn);
    s = (16 * g * UNIT) / (5 * UNIT - 4 * g);
    return neg ? -s : s;
  endfunction

  function automatic logic signed [18:0] ease(logic [3:0] c, logic signed [18:0] p);
    longint t, r, s, d, c1, u, u2;
    t = clamp_t(longint'(p));
    case (c)
      CURVE_SMOOTH: r = smooth_of(t);
      CURVE_SMOOTH_SQ: begin
        s = smooth_of(t);
        r = qmul(s, s);
      end
      CURVE_SMOOTHER: r = qmul(qmul(qmul(t, t), t), qmul(t, 6 * t - 15 * UNIT) + 10 * UNIT);
      CURVE_RUSH_INTO: r = 2 * smooth_of((UNIT + t) >>> 1) - UNIT;
      CURVE_RUSH_FROM: r = 2 * smooth_of(t >>> 1);
      CURVE_BACK: begin
        c1 = (170158 * UNIT + 50000) / 100000;
        u = t - UNIT;
        u2 = qmul(u, u);
        r = UNIT + qmul(c1 + UNIT, qmul(u2, u)) + qmul(c1, u2);
      end
      CURVE_ELASTIC: begin
        if (t <= 0) r = 0;
        else if (t >= UNIT) r = UNIT;
        else r = UNIT + qmul(pow2_neg(10 * t), wave_of(10 * t - 3 * (UNIT / 4)));
      end
      CURVE_THERE_BACK: begin
        d = 2 * t - UNIT;
        if (d < 0) d = -d;
        r = smooth_of(UNIT - d);
      end
      default: r = t;
    endcase
    if (r < -262144) r = -262144;
    if (r > 262143) r = 262143;
    return r[18:0];
  endfunction

  task automatic write_curve(logic [2:0] addr, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (addr == {2'b00, REG_CURVE_SELECT} * 4) cur_curve = val[3:0];
  endtask

  task automatic send_word(logic signed [18:0] v);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      progress_valid <= 0;
      @(posedge clk);
    end
    progress_valid <= 1;
    progress <= v;
    sb.note_progress(ease(cur_curve, v));
    do @(posedge clk); while (progress_stall);
  endtask

  task automatic drain;
    int n;
    progress_valid <= 0;
    n = 0;
    while (sb.pending_q.size() != 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
    repeat (ECE_LAT + 4) @(posedge clk);
  endtask

  function automatic logic signed [18:0] rand_progress;
    case ($urandom_range(5))
      0: return 19'($urandom);
      1: return 19'($urandom_range(65536 + 8) - 4);
      default: return 19'($urandom_range(65536));
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && eased_valid && !eased_stall) sb.check_eased(eased_value);
    eased_stall <= hold_off || (recv_idle > 0 && $urandom_range(99) < recv_idle);
  end

  initial begin
    #400000;
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    logic signed [18:0] edges[12];
    sb = new();
    edges = '{-19'sd262144, 19'sd262143, -19'sd1, 19'sd0, 19'sd1, 19'sd32768,
              19'sd65535, 19'sd65536, 19'sd65537, 19'sd16384, 19'sd49152, 19'sd6554};
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (edges[i]) send_word(edges[i]);
    drain();
    for (int c = 0; c < 16; c++) begin
      write_curve(3'd0, c);
      if (c == 9) write_curve(3'd4, 32'd5);
      if (c < 9) for (int i = 0; i < 8; i++) send_word(edges[(i + c) % 12]);
      send_idle = (c % 3 == 0) ? 10 : (c % 3 == 1) ? 76 : 0;
      recv_idle = (c % 3 == 0) ? 76 : (c % 3 == 1) ? 10 : 0;
      for (int i = 0; i < (c < 9 ? 120 : 20); i++) begin
        if (c == 7 && i == 20) begin
          fork
            begin
              hold_off = 1;
              repeat (120) @(posedge clk);
              hold_off = 0;
            end
          join_none
        end
        send_word(rand_progress());
      end
      drain();
    end
    write_curve(3'd0, 32'hFFFF_FFF8);
    send_idle = 0; recv_idle = 0;
    for (int i = 0; i < 60; i++) send_word(rand_progress());
    drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+design
design/ece_pkg.sv
design/ece_div.sv
design/ece_poly.sv
design/ece_elastic.sv
design/easing_curve_evaluator.sv
test/tb.sv
